// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the RTL field extractor module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    `ASSERT_CLK(lbl, clk, rstn, !(cond), msg)
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== hw/rtl/nmea_pkg.sv =====
// Types, constants and the field-to-slot map of the RMC field extractor.
package nmea_pkg;

    localparam int LINE_MAX_DEF    = 75;
    localparam int FIELD_CHARS_DEF = 12;
    localparam int NUM_TEXT        = 5;
    localparam int HDR_LEN         = 6;
    localparam int SLOT_W          = 3;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_V      = 8'h56;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [2:0] FID_STATUS    = 3'd5;
    localparam logic [2:0] CC_MAX        = 3'd7;
    localparam logic [2:0] CC_STATUS_FLD = 3'd2;
    localparam logic [2:0] CC_PARSED     = 3'd2;
    localparam logic [2:0] CC_FIX        = 3'd3;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_SEND = 3'b100
    } t_state;

    typedef struct packed {
        logic                hit;
        logic [SLOT_W-1:0]   idx;
    } t_slot;

    function automatic t_slot text_slot(input logic [2:0] field);
        t_slot r;
        r.hit = 1'b1;
        case (field)
            3'd1: r.idx = 3'd0;
            3'd3: r.idx = 3'd1;
            3'd4: r.idx = 3'd2;
            3'd5: r.idx = 3'd3;
            3'd6: r.idx = 3'd4;
            default: begin
                r.hit = 1'b0;
                r.idx = 3'd0;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/nmea_rmc_field_extractor_top.sv =====
// RMC sentence parser: stages fields per line, commits on newline, streams kept fields.
//
//  channel   dir  tdata                                  tuser        tlast
//  s_axis    in   [7:0] rx_byte                          -            -
//  m_axis    out  [3:0] char_index [11:4] char_value     [2:0] field  last_item
//                 [12] fix_valid [13] parsed_flag
//
// A byte that does not end an RMC line leaves the block idle; it is ready again next cycle.
// A committing newline starts the scan: each text slot is closed by a scan step, each
// character is a read of the field store, then a send, and the status item is a scan,
// then a send.
// The field store has a single registered read port, so each character is read before it is sent.
// Reset (i_rst_n low, synchronous) clears all lengths, flags and the sequencer.
// A stalled request on m_axis holds the sequencer; no input is taken until the status item goes.
`include "assert_macros.svh"

module nmea_rmc_field_extractor_top #(
    parameter int LINE_MAX    = nmea_pkg::LINE_MAX_DEF,
    parameter int FIELD_CHARS = nmea_pkg::FIELD_CHARS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [3:0] char_index, [11:4] char_value,
                                        // [12] fix_valid, [13] parsed_flag, zero above
    output logic [2:0]  m_axis_tuser,   // [2:0] field_id
    output logic        m_axis_tlast    // last_item
);

    localparam int LPW = $clog2(LINE_MAX + 1);
    localparam int LW  = $clog2(FIELD_CHARS + 1);
    localparam int IW  = $clog2(FIELD_CHARS);
    localparam int AW  = 1 + nmea_pkg::SLOT_W + IW;
    localparam int NT  = nmea_pkg::NUM_TEXT;
    localparam int SW  = nmea_pkg::SLOT_W;

    nmea_pkg::t_state r_state, n_state;

    logic [LPW-1:0]  r_lp, n_lp;
    logic            r_h0, n_h0, r_h4, n_h4, r_h5, n_h5;
    logic [2:0]      r_cc, n_cc;
    logic [LW-1:0]   r_stg_len  [NT];
    logic [LW-1:0]   n_stg_len  [NT];
    logic [LW-1:0]   r_kept_len [NT];
    logic [LW-1:0]   n_kept_len [NT];
    logic [NT-1:0]   r_done, n_done;
    logic [NT-1:0]   r_kb, n_kb;
    logic [7:0]      r_status, n_status;
    logic            r_fix, n_fix, r_parsed, n_parsed;
    logic [SW-1:0]   r_slot, n_slot;
    logic [LW-1:0]   r_idx, n_idx;
    logic [7:0]      r_rdata;

    logic [7:0]      mem [2**AW];
    logic            wr_en, rd_en;
    logic [AW-1:0]   wr_addr, rd_addr;

    logic            acc;
    logic [7:0]      rx;
    logic [LPW-1:0]  lp_eff;
    logic            hdr_ok;
    logic            last;
    nmea_pkg::t_slot sl;

    assign rx     = s_axis_tdata;
    assign acc    = s_axis_tvalid && s_axis_tready;
    assign lp_eff = (rx == nmea_pkg::CH_DOLLAR) ? '0 : r_lp;
    assign hdr_ok = r_h0 && r_h4 && r_h5;
    assign sl     = nmea_pkg::text_slot(r_cc);
    assign last   = (r_slot == SW'(NT));

    assign s_axis_tready = (r_state == nmea_pkg::S_IDLE);
    assign m_axis_tvalid = (r_state == nmea_pkg::S_SEND);
    assign m_axis_tuser  = r_slot;
    assign m_axis_tlast  = last;
    assign m_axis_tdata  = {2'b00, r_parsed, r_fix,
                            (last ? nmea_pkg::CH_NUL : r_rdata), 4'(r_idx)};

    always_comb begin
        n_state    = r_state;
        n_lp       = r_lp;
        n_h0       = r_h0;
        n_h4       = r_h4;
        n_h5       = r_h5;
        n_cc       = r_cc;
        n_stg_len  = r_stg_len;
        n_kept_len = r_kept_len;
        n_done     = r_done;
        n_kb       = r_kb;
        n_status   = r_status;
        n_fix      = r_fix;
        n_parsed   = r_parsed;
        n_slot     = r_slot;
        n_idx      = r_idx;
        wr_en      = 1'b0;
        wr_addr    = '0;
        rd_en      = 1'b0;
        rd_addr    = {r_kb[r_slot], r_slot, r_idx[IW-1:0]};

        case (r_state)
            nmea_pkg::S_IDLE: begin
                if (acc) begin
                    if (rx == nmea_pkg::CH_DOLLAR) begin
                        n_cc     = '0;
                        n_done   = '0;
                        n_status = nmea_pkg::CH_NUL;
                        for (int s = 0; s < NT; s++) begin
                            n_stg_len[s] = '0;
                        end
                    end
                    if (lp_eff < LPW'(nmea_pkg::HDR_LEN)) begin
                        n_lp = lp_eff + LPW'(1);
                        if (lp_eff == LPW'(0)) begin
                            n_h0 = (rx == nmea_pkg::CH_DOLLAR);
                        end
                        if (lp_eff == LPW'(4)) begin
                            n_h4 = (rx == nmea_pkg::CH_M);
                        end
                        if (lp_eff == LPW'(5)) begin
                            n_h5 = (rx == nmea_pkg::CH_C);
                        end
                    end else if (hdr_ok) begin
                        if (rx == nmea_pkg::CH_NL) begin
                            for (int s = 0; s < NT; s++) begin
                                if (r_done[s]) begin
                                    n_kept_len[s] = r_stg_len[s];
                                    n_kb[s]       = ~r_kb[s];
                                end
                                n_stg_len[s] = '0;
                            end
                            if (r_cc >= nmea_pkg::CC_PARSED) begin
                                n_parsed = 1'b1;
                            end
                            if (r_cc >= nmea_pkg::CC_FIX) begin
                                if (r_status == nmea_pkg::CH_A) begin
                                    n_fix = 1'b1;
                                end else if (r_status == nmea_pkg::CH_V) begin
                                    n_fix = 1'b0;
                                end
                            end
                            n_lp     = '0;
                            n_h0     = 1'b0;
                            n_h4     = 1'b0;
                            n_h5     = 1'b0;
                            n_cc     = '0;
                            n_done   = '0;
                            n_status = nmea_pkg::CH_NUL;
                            n_slot   = '0;
                            n_idx    = '0;
                            n_state  = nmea_pkg::S_SCAN;
                        end else if (r_lp < LPW'(LINE_MAX)) begin
                            n_lp = r_lp + LPW'(1);
                            if (rx == nmea_pkg::CH_COMMA) begin
                                if (sl.hit) begin
                                    n_done[sl.idx] = 1'b1;
                                end
                                if (r_cc != nmea_pkg::CC_MAX) begin
                                    n_cc = r_cc + 3'd1;
                                end
                            end else if (r_cc == nmea_pkg::CC_STATUS_FLD) begin
                                if (r_status == nmea_pkg::CH_NUL) begin
                                    n_status = rx;
                                end
                            end else if (sl.hit && (r_stg_len[sl.idx] < LW'(FIELD_CHARS))) begin
                                wr_en   = 1'b1;
                                wr_addr = {~r_kb[sl.idx], sl.idx, r_stg_len[sl.idx][IW-1:0]};
                                n_stg_len[sl.idx] = r_stg_len[sl.idx] + LW'(1);
                            end
                        end
                    end
                end
            end
            nmea_pkg::S_SCAN: begin
                if (last) begin
                    n_state = nmea_pkg::S_SEND;
                end else if (r_idx < r_kept_len[r_slot]) begin
                    rd_en   = 1'b1;
                    n_state = nmea_pkg::S_SEND;
                end else begin
                    n_slot = r_slot + SW'(1);
                    n_idx  = '0;
                end
            end
            nmea_pkg::S_SEND: begin
                if (m_axis_tready) begin
                    if (last) begin
                        n_state = nmea_pkg::S_IDLE;
                    end else begin
                        n_idx   = r_idx + LW'(1);
                        n_state = nmea_pkg::S_SCAN;
                    end
                end
            end
            default: begin
                n_state = nmea_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= rx;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= nmea_pkg::S_IDLE;
            r_lp     <= '0;
            r_h0     <= 1'b0;
            r_h4     <= 1'b0;
            r_h5     <= 1'b0;
            r_cc     <= '0;
            r_done   <= '0;
            r_kb     <= '0;
            r_status <= nmea_pkg::CH_NUL;
            r_fix    <= 1'b0;
            r_parsed <= 1'b0;
            r_slot   <= '0;
            r_idx    <= '0;
            for (int s = 0; s < NT; s++) begin
                r_stg_len[s]  <= '0;
                r_kept_len[s] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_lp       <= n_lp;
            r_h0       <= n_h0;
            r_h4       <= n_h4;
            r_h5       <= n_h5;
            r_cc       <= n_cc;
            r_done     <= n_done;
            r_kb       <= n_kb;
            r_status   <= n_status;
            r_fix      <= n_fix;
            r_parsed   <= n_parsed;
            r_slot     <= n_slot;
            r_idx      <= n_idx;
            r_stg_len  <= n_stg_len;
            r_kept_len <= n_kept_len;
        end
    end

    `ASSERT_NEVER(a_busy_excl, i_clk, i_rst_n, s_axis_tready && m_axis_tvalid,
        "ready while sending")
    `ASSERT_CLK(a_last_status, i_clk, i_rst_n,
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == nmea_pkg::FID_STATUS),
        "last item not status")
    `ASSERT_CLK(a_idx_in_len, i_clk, i_rst_n,
        (m_axis_tvalid && !m_axis_tlast) |-> (r_idx < r_kept_len[r_slot]),
        "char beyond kept length")
    `ASSERT_CLK(a_ready_after, i_clk, i_rst_n,
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready,
        "not ready after run")

endmodule

// ===== tb/rmc_line_checker.sv =====
`timescale 1ns / 1ps
// Checker for the RMC field extractor: mirrors the line parser and compares every accepted output item.
module rmc_line_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [15:0] i_m_axis_tdata,   // [3:0] char_index, [11:4] char_value,
                                          // [12] fix_valid, [13] parsed_flag
    input  logic [2:0]  i_m_axis_tuser,   // [2:0] field_id
    input  logic        i_m_axis_tlast,   // last_item
    output int          o_error_count,
    output int          o_pending
);

    localparam int LINE_LIMIT = nmea_pkg::LINE_MAX_DEF;
    localparam int FIELD_LEN  = nmea_pkg::FIELD_CHARS_DEF;
    localparam int NTXT       = nmea_pkg::NUM_TEXT;
    localparam int HDR        = nmea_pkg::HDR_LEN;
    localparam int MAX_PRINTS = 40;

    typedef struct packed {
        logic [2:0] field_id;
        logic [3:0] char_index;
        logic [7:0] char_value;
        logic       fix_valid;
        logic       parsed_flag;
        logic       last_item;
    } t_rmc_item;

    logic [6:0] line_pos;
    logic [7:0] addr_bytes [HDR];
    logic [2:0] comma_cnt;
    logic [7:0] stage_chars [NTXT][FIELD_LEN];
    logic [3:0] stage_len [NTXT];
    logic       stage_done [NTXT];
    logic [7:0] stage_status;
    logic [7:0] kept_chars [NTXT][FIELD_LEN];
    logic [3:0] kept_len [NTXT];
    logic       fix_flag;
    logic       parsed_seen;
    t_rmc_item  due_items[$];
    t_rmc_item  got_item;
    t_rmc_item  want_item;
    int         fail_count = 0;
    int         result_count = 0;

    assign o_error_count = fail_count;

    function automatic int slot_of_field(input logic [2:0] fld);
        case (fld)
            3'd1: return 0;
            3'd3: return 1;
            3'd4: return 2;
            3'd5: return 3;
            3'd6: return 4;
            default: return -1;
        endcase
    endfunction

    task automatic clear_line();
        comma_cnt    = '0;
        stage_status = nmea_pkg::CH_NUL;
        for (int s = 0; s < NTXT; s++) begin
            stage_len[s]  = '0;
            stage_done[s] = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        if (fail_count <= MAX_PRINTS) begin
            $display("[%0t] result %0d: %s is %0d, %0d was due", $time, result_count, what,
                     got, want);
        end
    endtask

    task automatic parse_rx_byte(input logic [7:0] b);
        int s;
        t_rmc_item item;
        if (b == nmea_pkg::CH_DOLLAR) begin
            line_pos = '0;
            clear_line();
        end
        if (line_pos < HDR) begin
            addr_bytes[line_pos] = b;
            line_pos++;
            return;
        end
        if (!(addr_bytes[0] == nmea_pkg::CH_DOLLAR && addr_bytes[4] == nmea_pkg::CH_M &&
              addr_bytes[5] == nmea_pkg::CH_C)) begin
            return;
        end
        if (b != nmea_pkg::CH_NL) begin
            if (line_pos < LINE_LIMIT) begin
                s = slot_of_field(comma_cnt);
                if (b == nmea_pkg::CH_COMMA) begin
                    if (s >= 0) stage_done[s] = 1'b1;
                    if (comma_cnt < nmea_pkg::CC_MAX) comma_cnt++;
                end else if (comma_cnt == nmea_pkg::CC_STATUS_FLD) begin
                    if (stage_status == nmea_pkg::CH_NUL) stage_status = b;
                end else if (s >= 0 && stage_len[s] < FIELD_LEN) begin
                    stage_chars[s][stage_len[s]] = b;
                    stage_len[s]++;
                end
                line_pos++;
            end
            return;
        end
        // commit every comma-terminated field, then stream the kept copies
        for (s = 0; s < NTXT; s++) begin
            if (stage_done[s]) begin
                kept_len[s] = stage_len[s];
                for (int k = 0; k < FIELD_LEN; k++) kept_chars[s][k] = stage_chars[s][k];
            end
        end
        if (comma_cnt >= nmea_pkg::CC_PARSED) parsed_seen = 1'b1;
        if (comma_cnt >= nmea_pkg::CC_FIX) begin
            if (stage_status == nmea_pkg::CH_A) fix_flag = 1'b1;
            else if (stage_status == nmea_pkg::CH_V) fix_flag = 1'b0;
        end
        for (s = 0; s < NTXT; s++) begin
            for (int k = 0; k < kept_len[s]; k++) begin
                item.field_id    = s[2:0];
                item.char_index  = k[3:0];
                item.char_value  = kept_chars[s][k];
                item.fix_valid   = fix_flag;
                item.parsed_flag = parsed_seen;
                item.last_item   = 1'b0;
                due_items.push_back(item);
            end
        end
        item.field_id    = nmea_pkg::FID_STATUS;
        item.char_index  = '0;
        item.char_value  = nmea_pkg::CH_NUL;
        item.fix_valid   = fix_flag;
        item.parsed_flag = parsed_seen;
        item.last_item   = 1'b1;
        due_items.push_back(item);
        line_pos = '0;
        for (int h = 0; h < HDR; h++) addr_bytes[h] = '0;
        clear_line();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            line_pos    = '0;
            clear_line();
            fix_flag    = 1'b0;
            parsed_seen = 1'b0;
            for (int h = 0; h < HDR; h++) addr_bytes[h] = '0;
            for (int s = 0; s < NTXT; s++) begin
                kept_len[s] = '0;
                for (int k = 0; k < FIELD_LEN; k++) begin
                    stage_chars[s][k] = '0;
                    kept_chars[s][k]  = '0;
                end
            end
            due_items.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got_item.field_id    = i_m_axis_tuser;
                got_item.char_index  = i_m_axis_tdata[3:0];
                got_item.char_value  = i_m_axis_tdata[11:4];
                got_item.fix_valid   = i_m_axis_tdata[12];
                got_item.parsed_flag = i_m_axis_tdata[13];
                got_item.last_item   = i_m_axis_tlast;
                result_count++;
                if (due_items.size() == 0) begin
                    report_mismatch("unrequested result, field_id", got_item.field_id, -1);
                end else begin
                    want_item = due_items.pop_front();
                    if (got_item.field_id != want_item.field_id)
                        report_mismatch("field_id", got_item.field_id, want_item.field_id);
                    if (got_item.char_index != want_item.char_index)
                        report_mismatch("char_index", got_item.char_index, want_item.char_index);
                    if (got_item.char_value != want_item.char_value)
                        report_mismatch("char_value", got_item.char_value, want_item.char_value);
                    if (got_item.fix_valid != want_item.fix_valid)
                        report_mismatch("fix_valid", got_item.fix_valid, want_item.fix_valid);
                    if (got_item.parsed_flag != want_item.parsed_flag)
                        report_mismatch("parsed_flag", got_item.parsed_flag,
                                        want_item.parsed_flag);
                    if (got_item.last_item != want_item.last_item)
                        report_mismatch("last_item", got_item.last_item, want_item.last_item);
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) parse_rx_byte(i_s_axis_tdata);
        end
        o_pending <= due_items.size();
    end

endmodule

// ===== tb/tb_nmea_rmc_field_extractor_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the RMC field extractor: byte stimulus, sink stalls, watchdog and verdict.
module tb_nmea_rmc_field_extractor_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 150;
    localparam int STIM_BYTES     = 290;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    int          error_count;
    int          pending;
    int          idle_cycles = 0;
    int          burst_left = 1;
    logic [9:0]  rdy_cnt = '0;
    logic [7:0]  line_bytes[$];

    nmea_rmc_field_extractor_top DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast)
    );

    rmc_line_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tuser  (m_tuser),
        .i_m_axis_tlast  (m_tlast),
        .o_error_count   (error_count),
        .o_pending       (pending)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        rdy_cnt <= rdy_cnt + 1'b1;
        case (rdy_cnt[9:8])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= ($urandom_range(0, 3) != 0);
            2'd2: m_tready <= (rdy_cnt[2:0] > 3'd2);
            default: m_tready <= ($urandom_range(0, 1) == 1);
        endcase
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [7:0] field_char();
        logic [7:0] b;
        if ($urandom_range(0, 3) != 0) return 8'h30 + 8'($urandom_range(0, 9));
        do b = 8'($urandom_range(0, 255));
        while (b == nmea_pkg::CH_DOLLAR || b == nmea_pkg::CH_COMMA || b == nmea_pkg::CH_NL);
        return b;
    endfunction

    function automatic logic [7:0] upper_letter();
        return 8'h41 + 8'($urandom_range(0, 25));
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 12);
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) send_byte(txt[i]);
    endtask

    // hold off until every due result has been taken
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic build_rmc_line();
        int nfld;
        int len;
        bit long_line;
        line_bytes.delete();
        line_bytes.push_back(nmea_pkg::CH_DOLLAR);
        line_bytes.push_back(($urandom_range(0, 9) == 0) ? field_char() : upper_letter());
        line_bytes.push_back(($urandom_range(0, 9) == 0) ? field_char() : upper_letter());
        line_bytes.push_back(($urandom_range(0, 9) == 0) ? field_char() : 8'h52);
        line_bytes.push_back(nmea_pkg::CH_M);
        line_bytes.push_back(nmea_pkg::CH_C);
        if ($urandom_range(0, 11) == 0) line_bytes[$urandom_range(1, 3)] = nmea_pkg::CH_NL;
        if ($urandom_range(0, 7) == 0) line_bytes.push_back(field_char());
        long_line = ($urandom_range(0, 9) == 0);
        nfld = ($urandom_range(0, 3) != 0) ? $urandom_range(6, 8) : $urandom_range(0, 9);
        for (int f = 1; f <= nfld; f++) begin
            line_bytes.push_back(nmea_pkg::CH_COMMA);
            if (f == 2) begin
                case ($urandom_range(0, 6))
                    0, 1: line_bytes.push_back(nmea_pkg::CH_A);
                    2: line_bytes.push_back(nmea_pkg::CH_V);
                    3: ;
                    4: begin
                        line_bytes.push_back(nmea_pkg::CH_NUL);
                        line_bytes.push_back(($urandom_range(0, 1) == 1) ? nmea_pkg::CH_A
                                                                          : nmea_pkg::CH_V);
                    end
                    5: line_bytes.push_back(field_char());
                    default: begin
                        line_bytes.push_back(nmea_pkg::CH_V);
                        line_bytes.push_back(nmea_pkg::CH_A);
                    end
                endcase
            end else begin
                if (long_line) len = $urandom_range(10, 16);
                else if ($urandom_range(0, 7) == 0) len = $urandom_range(12, 15);
                else len = $urandom_range(0, 5);
                repeat (len) line_bytes.push_back(field_char());
            end
        end
        if (nfld > 0 && $urandom_range(0, 9) < 7) line_bytes.push_back(nmea_pkg::CH_COMMA);
        if ($urandom_range(0, 9) != 0) line_bytes.push_back(nmea_pkg::CH_NL);
    endtask

    task automatic build_other_line();
        line_bytes.delete();
        line_bytes.push_back(nmea_pkg::CH_DOLLAR);
        line_bytes.push_back(upper_letter());
        line_bytes.push_back(upper_letter());
        line_bytes.push_back(upper_letter());
        if ($urandom_range(0, 1) == 1) begin
            line_bytes.push_back(nmea_pkg::CH_M);
            line_bytes.push_back(8'h41);
        end else begin
            line_bytes.push_back(8'h47);
            line_bytes.push_back(nmea_pkg::CH_C);
        end
        repeat ($urandom_range(2, 12)) begin
            line_bytes.push_back(($urandom_range(0, 3) == 0) ? nmea_pkg::CH_COMMA
                                                              : field_char());
        end
        line_bytes.push_back(nmea_pkg::CH_NL);
    endtask

    initial begin
        int pick;
        int sent_bytes;
        int line_no;
        sent_bytes = 0;
        line_no    = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // newline inside the address field, then an empty commit
        send_text("$G\nRMC\n");
        // extreme bytes: 0xFF in the time field, NUL before the status character
        send_text("$GPRMC,");
        send_byte(8'hFF);
        send_byte(nmea_pkg::CH_COMMA);
        send_byte(nmea_pkg::CH_NUL);
        send_text("A,\n");
        // another sentence type, dropped whole
        send_text("$GPGGA,9,\n");
        drain();

        while (sent_bytes < STIM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                build_rmc_line();
            end else if (pick < 90) begin
                build_other_line();
            end else begin
                line_bytes.delete();
                repeat ($urandom_range(1, 8)) line_bytes.push_back(8'($urandom_range(0, 255)));
            end
            sent_bytes += line_bytes.size();
            foreach (line_bytes[i]) send_byte(line_bytes[i]);
            line_no++;
            if (line_no == 8) drain();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/nmea_pkg.sv
hw/rtl/nmea_rmc_field_extractor_top.sv
tb/rmc_line_checker.sv
tb/tb_nmea_rmc_field_extractor_top.sv
